// ===== rtl/core/cps_pkg.sv =====
// Package for the compressor pump sequencer: step, operation, command and register codes.
`timescale 1ns / 1ps
package cps_pkg;

  // Sequencer steps
  localparam logic [3:0] StepIdle      = 4'd0;
  localparam logic [3:0] StepWaitNeed  = 4'd1;
  localparam logic [3:0] StepGeoStart  = 4'd2;
  localparam logic [3:0] StepStartDly  = 4'd3;
  localparam logic [3:0] StepCompStart = 4'd4;
  localparam logic [3:0] StepRun       = 4'd5;
  localparam logic [3:0] StepCompStop  = 4'd6;
  localparam logic [3:0] StepStopDly   = 4'd7;
  localparam logic [3:0] StepGeoStop   = 4'd8;

  // Operations carried in tuser
  localparam logic [1:0] OpTick      = 2'd0;
  localparam logic [1:0] OpStop      = 2'd1;
  localparam logic [1:0] OpForceStop = 2'd2;
  localparam logic [1:0] OpNone      = 2'd3;

  // Compressor commands
  localparam logic [1:0] CompNone  = 2'd0;
  localparam logic [1:0] CompStart = 2'd1;
  localparam logic [1:0] CompStop  = 2'd2;

  // Ground pump commands
  localparam logic [1:0] GeoNone      = 2'd0;
  localparam logic [1:0] GeoStart     = 2'd1;
  localparam logic [1:0] GeoStop      = 2'd2;
  localparam logic [1:0] GeoForceStop = 2'd3;

  // Register indexes
  localparam logic [2:0] RegGeoStartDelay = 3'd0;
  localparam logic [2:0] RegGeoStopDelay  = 3'd1;
  localparam logic [2:0] RegMinOffTime    = 3'd2;
  localparam logic [2:0] RegMinOnTime     = 3'd3;
  localparam logic [2:0] RegStartBelow    = 3'd4;
  localparam logic [2:0] RegStopAt        = 3'd5;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

endpackage

// ===== rtl/core/compressor_pump_sequencer.sv =====
// Top level of the heat pump compressor and ground pump start/stop sequencer.
`timescale 1ns / 1ps
// Each input transaction (tick, orderly stop, forced stop or none) is evaluated in the cycle it
// is accepted: the sequencer state updates at that edge and the result lands in the output
// register, visible in the cycle after. One transaction per cycle is taken as long as the
// output register is empty or being drained in the same cycle; the output register alone
// sets that rate.
// Configuration writes take effect at the edge where cfg_we_i is high.
module compressor_pump_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [cps_pkg::CfgIdxW-1:0]   cfg_addr_i,
  input  logic [cps_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: now_seconds[31:0], control_temp[43:32], health_mask[51:44],
  //        contours_ack[52], geo_ack[53], compressor_ack[54], zero pad[55]
  input  logic [cps_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: op[1:0]
  input  logic [1:0]                    s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: step_now[3:0], done_res[4], alarm[5], compressor_cmd[7:6], geo_cmd[9:8],
  //        contours_cmd[10], compressor_running[11], zero pad[15:12]
  output logic [cps_pkg::OutDataW-1:0]  m_axis_tdata
);
  import cps_pkg::*;

  // Configuration registers
  logic [15:0]        geo_start_delay_q, geo_stop_delay_q, min_off_time_q, min_on_time_q;
  logic signed [11:0] start_below_q, stop_at_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geo_start_delay_q <= 16'd180;
      geo_stop_delay_q  <= 16'd180;
      min_off_time_q    <= 16'd300;
      min_on_time_q     <= 16'd300;
      start_below_q     <= 12'sd400;
      stop_at_q         <= 12'sd450;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegGeoStartDelay: geo_start_delay_q <= cfg_wdata_i;
        RegGeoStopDelay:  geo_stop_delay_q  <= cfg_wdata_i;
        RegMinOffTime:    min_off_time_q    <= cfg_wdata_i;
        RegMinOnTime:     min_on_time_q     <= cfg_wdata_i;
        RegStartBelow:    start_below_q     <= $signed(cfg_wdata_i[11:0]);
        RegStopAt:        stop_at_q         <= $signed(cfg_wdata_i[11:0]);
        default: ;
      endcase
    end
  end

  // Unpack the input transaction
  logic [1:0]         op;
  logic [31:0]        now_s;
  logic signed [11:0] temp;
  logic [7:0]         mask;
  logic               c_ack, g_ack, k_ack;

  assign op    = s_axis_tuser;
  assign now_s = s_axis_tdata[31:0];
  assign temp  = $signed(s_axis_tdata[43:32]);
  assign mask  = s_axis_tdata[51:44];
  assign c_ack = s_axis_tdata[52];
  assign g_ack = s_axis_tdata[53];
  assign k_ack = s_axis_tdata[54];

  // Sequencer state
  logic [3:0]  step_q, step_d;
  logic [31:0] phase_q, phase_d;
  logic        comp_on_q, comp_on_d;
  logic [31:0] comp_chg_q, comp_chg_d;

  // Result fields
  logic       done, healthy, ktcmd;
  logic [1:0] ccmd, gcmd;

  // Elapsed-time and temperature compares
  logic [31:0] since_phase, since_change;
  logic        start_need, stop_reached;
  logic        start_dly_ok, stop_dly_ok, off_ok, on_ok;

  assign healthy      = (mask == 8'hFF);
  assign start_need   = temp < start_below_q;
  assign stop_reached = temp >= stop_at_q;
  assign since_phase  = now_s - phase_q;
  assign since_change = now_s - comp_chg_q;
  assign start_dly_ok = since_phase >= {16'd0, geo_start_delay_q};
  assign stop_dly_ok  = since_phase >= {16'd0, geo_stop_delay_q};
  assign off_ok       = since_change > {16'd0, min_off_time_q};
  assign on_ok        = since_change > {16'd0, min_on_time_q};

  // Next state and commands for one transaction
  always_comb begin
    step_d     = step_q;
    phase_d    = phase_q;
    comp_on_d  = comp_on_q;
    comp_chg_d = comp_chg_q;
    done       = 1'b0;
    ccmd       = CompNone;
    gcmd       = GeoNone;
    ktcmd      = 1'b0;
    unique case (op)
      OpTick: begin
        unique case (step_q)
          StepIdle: step_d = StepWaitNeed;
          StepWaitNeed: begin
            if (start_need) begin
              ktcmd = 1'b1;
              if (c_ack) step_d = StepGeoStart;
            end
          end
          StepGeoStart: begin
            if (start_need) begin
              gcmd = GeoStart;
              if (g_ack) begin
                step_d  = StepStartDly;
                phase_d = now_s;
              end
            end else begin
              step_d = StepWaitNeed;
            end
          end
          StepStartDly: if (start_dly_ok) step_d = StepCompStart;
          StepCompStart: begin
            if (start_need) begin
              if (comp_on_q) begin
                step_d = StepRun;
              end else if (healthy && off_ok) begin
                ccmd       = CompStart;
                comp_on_d  = 1'b1;
                comp_chg_d = now_s;
                step_d     = StepRun;
              end
            end else begin
              step_d = StepCompStop;
            end
          end
          StepRun: if (stop_reached) step_d = StepCompStop;
          StepCompStop: begin
            ccmd = CompStop;
            if (k_ack) begin
              if (comp_on_q) begin
                comp_on_d  = 1'b0;
                comp_chg_d = now_s;
              end
              step_d  = StepStopDly;
              phase_d = now_s;
            end
          end
          StepStopDly: if (stop_dly_ok) step_d = StepGeoStop;
          StepGeoStop: begin
            gcmd = GeoStop;
            if (g_ack) begin
              step_d = StepWaitNeed;
              done   = 1'b1;
            end
          end
          default: ;
        endcase
      end
      OpStop: begin
        priority if (step_q == StepIdle || step_q == StepWaitNeed) begin
          step_d = StepIdle;
          done   = 1'b1;
        end else if (step_q == StepGeoStart || step_q == StepStartDly ||
                     step_q == StepStopDly || step_q == StepGeoStop) begin
          gcmd = GeoStop;
          if (g_ack) begin
            step_d  = StepIdle;
            done    = 1'b1;
            phase_d = now_s;
          end
        end else if (step_q == StepCompStart || step_q == StepRun ||
                     step_q == StepCompStop) begin
          if (!comp_on_q) begin
            step_d = StepGeoStop;
          end else if (on_ok) begin
            ccmd       = CompStop;
            comp_on_d  = 1'b0;
            comp_chg_d = now_s;
            step_d     = StepGeoStop;
          end
        end else begin
          step_d = step_q;
        end
      end
      OpForceStop: begin
        ccmd = CompStop;
        gcmd = GeoForceStop;
        if (k_ack && comp_on_q) begin
          comp_on_d  = 1'b0;
          comp_chg_d = now_s;
        end
        done = k_ack & g_ack;
      end
      OpNone: ;
      default: ;
    endcase
  end

  // Handshake: take a transaction when the output register is free or draining
  logic accept;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= StepIdle;
      phase_q    <= '0;
      comp_on_q  <= 1'b0;
      comp_chg_q <= '0;
    end else if (accept) begin
      step_q     <= step_d;
      phase_q    <= phase_d;
      comp_on_q  <= comp_on_d;
      comp_chg_q <= comp_chg_d;
    end
  end

  // Output register
  logic                valid_q;
  logic [OutDataW-1:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= {4'd0, comp_on_d, ktcmd, gcmd, ccmd, ~healthy, done, step_d};
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule
